// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/abbc_pkg.sv =====
// ----------------------------------------------------------------------------
// abbc_pkg
// Types, constants and helpers of the trio ABBA/BABA/BBAA accumulator.
// ----------------------------------------------------------------------------
package abbc_pkg;

    localparam int TRIO_W    = 10;
    localparam int DEPTH     = 1024;
    localparam int FREQ_BITS = 16;
    localparam int FREQ_W    = FREQ_BITS + 1;
    localparam int PROD_W    = 2 * FREQ_W;
    localparam int SUM_W     = 64;
    localparam int CNT_W     = 32;
    localparam int WS_W      = 20;
    localparam int D_W       = 16;
    localparam int Q_W       = 16;
    localparam int DEN_W     = SUM_W + 1;
    localparam int REM_W     = SUM_W + 2;
    localparam int BIT_IDX_W = 5;
    localparam int SEL_W     = 2;
    localparam int NUM_D     = 3;
    localparam int MASK_W    = 4;
    localparam int CHOICE_W  = 2;
    localparam int ZFLAG_W   = 3;

    localparam logic [WS_W-1:0]   WS_RESET  = 20'd20000;
    localparam logic [FREQ_W-1:0] FREQ_ONE  = FREQ_W'(1) << FREQ_BITS;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [TRIO_W-1:0] LAST_ROW  = TRIO_W'(DEPTH - 1);
    localparam logic [TRIO_W-1:0] MUL_LAST  = TRIO_W'(2);
    localparam logic [TRIO_W-1:0] MOD_LAST  = TRIO_W'(CNT_W - 1);
    localparam logic [TRIO_W-1:0] DIV_LAST  = TRIO_W'(Q_W - 1);
    localparam logic [SEL_W-1:0]  SEL_LAST  = SEL_W'(NUM_D - 1);
    localparam logic [Q_W-1:0]    D_POS_MAX = 16'h7FFF;

    localparam logic KIND_ACC = 1'b0;
    localparam logic KIND_RO  = 1'b1;

    localparam logic [CHOICE_W-1:0] DMIN_FIRST  = 2'd0;
    localparam logic [CHOICE_W-1:0] DMIN_SECOND = 2'd1;
    localparam logic [CHOICE_W-1:0] DMIN_THIRD  = 2'd2;
    localparam logic [CHOICE_W-1:0] PAT_BBAA    = 2'd0;
    localparam logic [CHOICE_W-1:0] PAT_BABA    = 2'd1;
    localparam logic [CHOICE_W-1:0] PAT_ABBA    = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_UPD,
        ST_MSTEP,
        ST_DINIT,
        ST_DSTEP,
        ST_DEND,
        ST_WR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0] abba_run;
        logic [SUM_W-1:0] baba_run;
        logic [SUM_W-1:0] bbaa_run;
        logic [SUM_W-1:0] abba_win;
        logic [SUM_W-1:0] baba_win;
        logic [SUM_W-1:0] bbaa_win;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic              load;
        logic              clr_wr;
        logic              mul_en;
        logic              upd;
        logic              mod_en;
        logic              div_init;
        logic              div_en;
        logic              div_end;
        logic              wr;
        logic              win_clr;
        logic              emit;
        logic [TRIO_W-1:0] idx;
        logic [SEL_W-1:0]  sel;
    } cmd_t;

    typedef struct packed {
        logic ro;
        logic skip;
        logic no_window;
        logic mod_zero;
    } stat_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/core/abba_baba_trio_accumulator_unit.sv =====
// Sequence after the accepting edge: a skipped site goes back to idle; accumulate runs the
// 9-step multiply chain, then the 32-step window remainder unless window_size is 0 or the count
// is saturated; window close and readout run three 16-step D divisions; the result beat is registered after ST_OUT.
// Throughput: one item at a time, start taken only while busy is low; results never stall.
// Reset: window_size returns to 20000 and the trio table is cleared by a pass
// over all 1024 rows during which busy stays high.
// ----------------------------------------------------------------------------
// abba_baba_trio_accumulator_unit
// Per-trio ABBA/BABA/BBAA totals with window and global Patterson D values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abba_baba_trio_accumulator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cfg_we,
    input  logic [abbc_pkg::WS_W-1:0]       cfg_wdata,
    input  logic                            kind,
    input  logic [abbc_pkg::TRIO_W-1:0]     trio,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_first,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_second,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_third,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_outgroup,
    input  logic [abbc_pkg::MASK_W-1:0]     missing_mask,
    output logic                            done,
    output logic [abbc_pkg::TRIO_W-1:0]     trio_echo,
    output logic signed [abbc_pkg::D_W-1:0] d_first,
    output logic signed [abbc_pkg::D_W-1:0] d_second,
    output logic signed [abbc_pkg::D_W-1:0] d_third,
    output logic [abbc_pkg::ZFLAG_W-1:0]    zero_denominator,
    output logic [abbc_pkg::SUM_W-1:0]      abba_sum,
    output logic [abbc_pkg::SUM_W-1:0]      baba_sum,
    output logic [abbc_pkg::SUM_W-1:0]      bbaa_sum,
    output logic [abbc_pkg::CNT_W-1:0]      sites_used,
    output logic [abbc_pkg::CHOICE_W-1:0]   dmin_choice,
    output logic [abbc_pkg::CHOICE_W-1:0]   majority_pattern
);
    import abbc_pkg::*;

    logic [WS_W-1:0] window_size_reg;
    cmd_t            cmd;
    stat_t           stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= WS_RESET;
        else if (cfg_we)
            window_size_reg <= cfg_wdata;
    end

    abbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    abbc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .kind             (kind),
        .trio             (trio),
        .freq_first       (freq_first),
        .freq_second      (freq_second),
        .freq_third       (freq_third),
        .freq_outgroup    (freq_outgroup),
        .missing_mask     (missing_mask),
        .window_size      (window_size_reg),
        .stat             (stat),
        .done             (done),
        .trio_echo        (trio_echo),
        .d_first          (d_first),
        .d_second         (d_second),
        .d_third          (d_third),
        .zero_denominator (zero_denominator),
        .abba_sum         (abba_sum),
        .baba_sum         (baba_sum),
        .bbaa_sum         (bbaa_sum),
        .sites_used       (sites_used),
        .dmin_choice      (dmin_choice),
        .majority_pattern (majority_pattern)
    );

    `ASSERT_IMPLIES(a_done_after_work, done, $past(busy), "result beat without preceding work")

endmodule

// ===== rtl/core/abbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// abbc_ctrl
// Sequencer: clearing pass, multiply steps, window check, D divisions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abbc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  abbc_pkg::stat_t stat,
    output abbc_pkg::cmd_t  cmd,
    output logic          busy
);
    import abbc_pkg::*;

    state_t            state_reg, state_next;
    logic [TRIO_W-1:0] cnt_reg, cnt_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cnt_next = '0;
                sel_next = '0;
                if (stat.ro)
                    state_next = ST_DINIT;
                else if (stat.skip)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next = '0;
                    if (sel_reg == SEL_LAST)
                    begin
                        sel_next   = '0;
                        state_next = ST_UPD;
                    end
                    else
                        sel_next = sel_reg + 1'b1;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_UPD:
            begin
                cnt_next   = '0;
                state_next = stat.no_window ? ST_WR : ST_MSTEP;
            end
            ST_MSTEP:
            begin
                if (cnt_reg == MOD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = stat.mod_zero ? ST_DINIT : ST_WR;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DINIT:
            begin
                cnt_next   = '0;
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_DEND;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DEND:
            begin
                cnt_next = '0;
                if (sel_reg == SEL_LAST)
                begin
                    sel_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_DINIT;
                end
            end
            ST_WR:    state_next = ST_IDLE;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.idx      = cnt_reg;
        cmd.sel      = sel_reg;
        cmd.load     = (state_reg == ST_IDLE) && start;
        cmd.clr_wr   = (state_reg == ST_CLEAR);
        cmd.mul_en   = (state_reg == ST_MUL);
        cmd.upd      = (state_reg == ST_UPD);
        cmd.mod_en   = (state_reg == ST_MSTEP);
        cmd.div_init = (state_reg == ST_DINIT);
        cmd.div_en   = (state_reg == ST_DSTEP);
        cmd.div_end  = (state_reg == ST_DEND);
        cmd.wr       = (state_reg == ST_WR) || ((state_reg == ST_OUT) && !stat.ro);
        cmd.win_clr  = (state_reg == ST_OUT);
        cmd.emit     = (state_reg == ST_OUT);
        busy         = (state_reg != ST_IDLE);
    end

    `ASSERT_NEXT(a_mod_exit, (state_reg == ST_MSTEP) && (cnt_reg == MOD_LAST), (state_reg == ST_WR) || (state_reg == ST_DINIT), "window check left to a wrong state")
    `ASSERT_IMPLIES(a_sel_range, (state_reg == ST_MUL) || (state_reg == ST_DSTEP), sel_reg != 2'd3, "pattern select out of range")

endmodule

// ===== rtl/core/abbc_dp.sv =====
// ----------------------------------------------------------------------------
// abbc_dp
// Trio table, shared multiplier, window remainder and D divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abbc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  abbc_pkg::cmd_t                  cmd,
    input  logic                            kind,
    input  logic [abbc_pkg::TRIO_W-1:0]     trio,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_first,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_second,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_third,
    input  logic [abbc_pkg::FREQ_W-1:0]     freq_outgroup,
    input  logic [abbc_pkg::MASK_W-1:0]     missing_mask,
    input  logic [abbc_pkg::WS_W-1:0]       window_size,
    output abbc_pkg::stat_t                 stat,
    output logic                            done,
    output logic [abbc_pkg::TRIO_W-1:0]     trio_echo,
    output logic signed [abbc_pkg::D_W-1:0] d_first,
    output logic signed [abbc_pkg::D_W-1:0] d_second,
    output logic signed [abbc_pkg::D_W-1:0] d_third,
    output logic [abbc_pkg::ZFLAG_W-1:0]    zero_denominator,
    output logic [abbc_pkg::SUM_W-1:0]      abba_sum,
    output logic [abbc_pkg::SUM_W-1:0]      baba_sum,
    output logic [abbc_pkg::SUM_W-1:0]      bbaa_sum,
    output logic [abbc_pkg::CNT_W-1:0]      sites_used,
    output logic [abbc_pkg::CHOICE_W-1:0]   dmin_choice,
    output logic [abbc_pkg::CHOICE_W-1:0]   majority_pattern
);
    import abbc_pkg::*;

    function automatic logic [FREQ_W-1:0] clamp(input logic [FREQ_W-1:0] f);
        return (f > FREQ_ONE) ? FREQ_ONE : f;
    endfunction

    entry_t            mem [DEPTH];
    entry_t            rd_reg, entry_reg, entry_next, wr_data;
    logic              mem_we;
    logic [TRIO_W-1:0] wr_addr;

    logic              kind_reg, skip_reg;
    logic [TRIO_W-1:0] trio_reg;
    logic [FREQ_W-1:0] f0_reg, f1_reg, f2_reg, f3_reg;

    logic [FREQ_W-1:0] t_reg;
    logic [PROD_W-1:0] p_reg [NUM_D];
    logic [FREQ_W-1:0] mx, my, mz, wo, ma, mb;
    logic [PROD_W-1:0] prod;

    logic [WS_W-1:0]   mrem_reg;
    logic [WS_W:0]     mshift;
    logic [WS_W-1:0]   mstep;

    logic [SUM_W-1:0]  sa, sb, sc, dx, dy;
    logic [REM_W-1:0]  drem_reg, drem_sub, drem_sel;
    logic [DEN_W-1:0]  dden_reg;
    logic [Q_W-1:0]    q_reg, q_neg;
    logic              neg_reg, dzero_reg, dge;
    logic [Q_W-1:0]    mag_reg [NUM_D];
    logic [D_W-1:0]    dval_reg [NUM_D];
    logic [NUM_D-1:0]  zflag_reg;
    logic [CHOICE_W-1:0] dmin, maj;

    logic              done_reg;

    // Table: clearing pass, write-back and registered read at accept
    always_comb
    begin
        mem_we  = cmd.clr_wr || cmd.wr;
        wr_addr = cmd.clr_wr ? cmd.idx : trio_reg;
        wr_data = entry_reg;
        if (cmd.clr_wr)
            wr_data = '0;
        else if (cmd.win_clr)
        begin
            wr_data.abba_win = '0;
            wr_data.baba_win = '0;
            wr_data.bbaa_win = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (cmd.load)
            rd_reg <= mem[trio];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            trio_reg <= trio;
            skip_reg <= (missing_mask != '0);
            f0_reg   <= clamp(freq_first);
            f1_reg   <= clamp(freq_second);
            f2_reg   <= clamp(freq_third);
            f3_reg   <= clamp(freq_outgroup);
        end
    end

    // Pattern products: x*y, then *z, then *outgroup complement
    always_comb
    begin
        wo = FREQ_ONE - f3_reg;
        case (cmd.sel)
            2'd0:
            begin
                mx = FREQ_ONE - f0_reg; my = f1_reg; mz = f2_reg;
            end
            2'd1:
            begin
                mx = f0_reg; my = FREQ_ONE - f1_reg; mz = f2_reg;
            end
            default:
            begin
                mx = FREQ_ONE - f2_reg; my = f1_reg; mz = f0_reg;
            end
        endcase
        case (cmd.idx[1:0])
            2'd0:    begin ma = mx;    mb = my; end
            2'd1:    begin ma = t_reg; mb = mz; end
            default: begin ma = t_reg; mb = wo; end
        endcase
        prod = PROD_W'(ma) * PROD_W'(mb);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            if (cmd.idx[1:0] == 2'd2)
                p_reg[cmd.sel] <= prod;
            else
                t_reg <= prod[FREQ_BITS +: FREQ_W];
        end
    end

    // Read-modify-write of the addressed entry
    always_comb
    begin
        entry_next          = rd_reg;
        entry_next.abba_run = sat_add(rd_reg.abba_run, SUM_W'(p_reg[0]));
        entry_next.baba_run = sat_add(rd_reg.baba_run, SUM_W'(p_reg[1]));
        entry_next.bbaa_run = sat_add(rd_reg.bbaa_run, SUM_W'(p_reg[2]));
        entry_next.abba_win = sat_add(rd_reg.abba_win, SUM_W'(p_reg[0]));
        entry_next.baba_win = sat_add(rd_reg.baba_win, SUM_W'(p_reg[1]));
        entry_next.bbaa_win = sat_add(rd_reg.bbaa_win, SUM_W'(p_reg[2]));
        if (rd_reg.count != CNT_MAX)
            entry_next.count = rd_reg.count + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
            entry_reg <= entry_next;
    end

    // Window check: remainder of the count, one bit a cycle from the top
    always_comb
    begin
        mshift = {mrem_reg, entry_reg.count[~cmd.idx[BIT_IDX_W-1:0]]};
        mstep  = (mshift >= {1'b0, window_size}) ?
                 WS_W'(mshift - {1'b0, window_size}) : mshift[WS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
            mrem_reg <= '0;
        else if (cmd.mod_en)
            mrem_reg <= mstep;
    end

    // D divider: restoring, one quotient bit a cycle
    always_comb
    begin
        if (kind_reg == KIND_RO)
        begin
            sa = rd_reg.abba_run; sb = rd_reg.baba_run; sc = rd_reg.bbaa_run;
        end
        else
        begin
            sa = entry_reg.abba_win; sb = entry_reg.baba_win; sc = entry_reg.bbaa_win;
        end
        case (cmd.sel)
            2'd0:    begin dx = sa; dy = sb; end
            2'd1:    begin dx = sa; dy = sc; end
            default: begin dx = sc; dy = sb; end
        endcase
        dge      = (drem_reg >= {1'b0, dden_reg});
        drem_sub = drem_reg - {1'b0, dden_reg};
        drem_sel = dge ? drem_sub : drem_reg;
        q_neg    = ~q_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            drem_reg  <= {2'b00, (dx >= dy) ? (dx - dy) : (dy - dx)};
            dden_reg  <= {1'b0, dx} + {1'b0, dy};
            neg_reg   <= (dx < dy);
            dzero_reg <= (dx == '0) && (dy == '0);
            q_reg     <= '0;
        end
        else if (cmd.div_en)
        begin
            drem_reg <= {drem_sel[REM_W-2:0], 1'b0};
            q_reg    <= {q_reg[Q_W-2:0], dge};
        end
        if (cmd.div_end)
        begin
            zflag_reg[cmd.sel] <= dzero_reg;
            mag_reg[cmd.sel]   <= dzero_reg ? '0 : q_reg;
            if (dzero_reg)
                dval_reg[cmd.sel] <= '0;
            else if (neg_reg)
                dval_reg[cmd.sel] <= q_neg;
            else
                dval_reg[cmd.sel] <= (q_reg > D_POS_MAX) ? D_POS_MAX : q_reg;
        end
    end

    // Decisions for readout
    always_comb
    begin
        if (mag_reg[0] <= mag_reg[1] && mag_reg[0] <= mag_reg[2])
            dmin = DMIN_FIRST;
        else if (mag_reg[1] <= mag_reg[2])
            dmin = DMIN_SECOND;
        else
            dmin = DMIN_THIRD;
        if (rd_reg.bbaa_run >= rd_reg.baba_run && rd_reg.bbaa_run >= rd_reg.abba_run)
            maj = PAT_BBAA;
        else if (rd_reg.baba_run >= rd_reg.abba_run)
            maj = PAT_BABA;
        else
            maj = PAT_ABBA;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            trio_echo        <= trio_reg;
            d_first          <= dval_reg[0];
            d_second         <= dval_reg[1];
            d_third          <= dval_reg[2];
            zero_denominator <= zflag_reg;
            if (kind_reg == KIND_RO)
            begin
                abba_sum         <= rd_reg.abba_run;
                baba_sum         <= rd_reg.baba_run;
                bbaa_sum         <= rd_reg.bbaa_run;
                sites_used       <= rd_reg.count;
                dmin_choice      <= dmin;
                majority_pattern <= maj;
            end
            else
            begin
                abba_sum         <= '0;
                baba_sum         <= '0;
                bbaa_sum         <= '0;
                sites_used       <= entry_reg.count;
                dmin_choice      <= DMIN_FIRST;
                majority_pattern <= PAT_BBAA;
            end
        end
    end

    always_comb
    begin
        done           = done_reg;
        stat.ro        = (kind_reg == KIND_RO);
        stat.skip      = skip_reg;
        stat.no_window = (rd_reg.count == CNT_MAX) || (window_size == '0);
        stat.mod_zero  = (mstep == '0);
    end

    `ASSERT_NEXT(a_single_beat, done_reg, !done_reg, "result strobe held for two cycles")

endmodule
